// ===== rtl/core/mp2_pkg.sv =====
// shared constants, register codes and float compare helpers for the 2x2 max pool
package mp2_pkg;

	localparam int LANES       = 4;
	localparam int MAX_ROW_DEF = 1024;
	localparam int ADDR_W      = 3;
	localparam int DATA_W      = 32;

	localparam logic [10:0] ROW_WIDTH_RST = 11'd1024;
	localparam logic [20:0] PLANE_RST     = 21'd1048576;
	localparam logic [20:0] PLANE_LIMIT   = 21'd1048576;

	// register select is address bit 2
	localparam logic REG_ROW_WIDTH = 1'b0;
	localparam logic REG_PLANE     = 1'b1;

	typedef logic [LANES-1:0][31:0] pixel_t;

	function automatic logic is_nan(input logic [31:0] v);
		return (v[30:23] == 8'hFF) && (v[22:0] != 23'd0);
	endfunction

	function automatic logic [31:0] order_key(input logic [31:0] v);
		return v[31] ? ~v : {1'b1, v[30:0]};
	endfunction

	// v replaces the running maximum m only when strictly greater
	function automatic logic [31:0] max_step(input logic [31:0] m, input logic [31:0] v);
		logic gt;
		gt = !is_nan(v) && !is_nan(m) && !((v[30:0] == 31'd0) && (m[30:0] == 31'd0))
			&& (order_key(v) > order_key(m));
		return gt ? v : m;
	endfunction

endpackage

// ===== rtl/core/mp2_line_ram.sv =====
// single-port line store with registered read data
module mp2_line_ram #(
	parameter int DEPTH = mp2_pkg::MAX_ROW_DEF,
	parameter int WIDTH = mp2_pkg::LANES * 32,
	parameter int AW    = $clog2(mp2_pkg::MAX_ROW_DEF)
) (
	input  logic             clk,
	input  logic             en,
	input  logic             we,
	input  logic [AW-1:0]    addr,
	input  logic [WIDTH-1:0] wdata,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem[addr] <= wdata;
			end else begin
				rdata <= mem[addr];
			end
		end
	end

endmodule

// ===== rtl/core/max_pool_2x2_stream_top.sv =====
// 2x2 stride-2 max pooling over a raster pixel stream, four float lanes
//
//  channel  direction  handshake            payload
//  in       sink       in_valid / in_stall  lane_a..lane_d
//  out      source     out_valid/out_stall  max_a..max_d
//  cfg      apb slave  psel/penable/pready  row_width, plane_pixels
//
// one pixel per cycle; one line-store access per pixel (write on even rows,
// read on odd rows) sets the rate. a result is registered through s1 and s2
// after the pixel that closes its window. a held result (out_valid with
// out_stall) freezes the whole pipe and raises in_stall.
// reset clears counters and valids; the line store is not cleared.
module max_pool_2x2_stream_top #(
	parameter int MAX_ROW = mp2_pkg::MAX_ROW_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [31:0]                lane_a,
	input  logic [31:0]                lane_b,
	input  logic [31:0]                lane_c,
	input  logic [31:0]                lane_d,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [31:0]                max_a,
	output logic [31:0]                max_b,
	output logic [31:0]                max_c,
	output logic [31:0]                max_d,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [mp2_pkg::ADDR_W-1:0] paddr,
	input  logic [mp2_pkg::DATA_W-1:0] pwdata,
	output logic [mp2_pkg::DATA_W-1:0] prdata,
	output logic                       pready
);

	localparam int CW  = $clog2(MAX_ROW);
	localparam int CW1 = $clog2(MAX_ROW + 1);
	localparam int PW  = mp2_pkg::LANES * 32;

	logic [10:0] row_width_q;
	logic [20:0] plane_pixels_q;

	logic [CW-1:0] column_q;
	logic          row_odd_q;
	logic [19:0]   plane_count_q;

	mp2_pkg::pixel_t cur;
	mp2_pkg::pixel_t prior_q;
	mp2_pkg::pixel_t rd_data;
	mp2_pkg::pixel_t al_q;

	logic            valid_s1, emit_s1, keep_al_s1;
	mp2_pkg::pixel_t cur_s1, prior_s1;
	logic            valid_s2;
	mp2_pkg::pixel_t m_s2, cur_s2;
	mp2_pkg::pixel_t result;

	logic            en, accept;
	logic [CW1-1:0]  w_eff;
	logic [CW-1:0]   w_last;
	logic [20:0]     plane_eff;
	logic            last_pixel;
	logic [PW-1:0]   ram_rdata;

	// configuration port
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_width_q    <= mp2_pkg::ROW_WIDTH_RST;
			plane_pixels_q <= mp2_pkg::PLANE_RST;
		end else if (psel && penable && pwrite) begin
			case (paddr[2])
				mp2_pkg::REG_ROW_WIDTH: row_width_q    <= pwdata[10:0];
				mp2_pkg::REG_PLANE:     plane_pixels_q <= pwdata[20:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			mp2_pkg::REG_ROW_WIDTH: prdata = {21'd0, row_width_q};
			mp2_pkg::REG_PLANE:     prdata = {11'd0, plane_pixels_q};
			default:                prdata = '0;
		endcase
	end

	// flow control: whole pipe moves unless a result is held
	assign en       = !(out_valid && out_stall);
	assign in_stall = !en;
	assign accept   = in_valid && en;

	assign cur[0] = lane_a;
	assign cur[1] = lane_b;
	assign cur[2] = lane_c;
	assign cur[3] = lane_d;

	always_comb begin
		if (row_width_q == 11'd0 || 32'(row_width_q) > 32'(MAX_ROW)) begin
			w_eff = CW1'(MAX_ROW);
		end else begin
			w_eff = CW1'(row_width_q);
		end
		w_last = CW'(w_eff - CW1'(1));
		if (plane_pixels_q == 21'd0) begin
			plane_eff = 21'd1;
		end else if (plane_pixels_q > mp2_pkg::PLANE_LIMIT) begin
			plane_eff = mp2_pkg::PLANE_LIMIT;
		end else begin
			plane_eff = plane_pixels_q;
		end
		last_pixel = ({1'b0, plane_count_q} + 21'd1) >= plane_eff;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			column_q      <= '0;
			row_odd_q     <= 1'b0;
			plane_count_q <= '0;
		end else if (accept) begin
			if (last_pixel) begin
				column_q      <= '0;
				row_odd_q     <= 1'b0;
				plane_count_q <= '0;
			end else begin
				plane_count_q <= plane_count_q + 20'd1;
				if (column_q >= w_last) begin
					column_q  <= '0;
					row_odd_q <= !row_odd_q;
				end else begin
					column_q <= column_q + CW'(1);
				end
			end
		end
	end

	// even rows write the store, odd rows read it
	mp2_line_ram #(
		.DEPTH(MAX_ROW),
		.WIDTH(PW),
		.AW   (CW)
	) u_line_ram (
		.clk  (clk),
		.en   (accept),
		.we   (!row_odd_q),
		.addr (column_q),
		.wdata(PW'(cur)),
		.rdata(ram_rdata)
	);

	assign rd_data = mp2_pkg::pixel_t'(ram_rdata);

	always_ff @(posedge clk) begin
		if (accept) begin
			prior_q  <= cur;
			cur_s1   <= cur;
			prior_s1 <= prior_q;
		end
		// above-left comes from the odd-row read one pixel earlier
		if (en && valid_s1 && keep_al_s1) begin
			al_q <= rd_data;
		end
		if (en) begin
			for (int p = 0; p < mp2_pkg::LANES; p++) begin
				m_s2[p] <= mp2_pkg::max_step(mp2_pkg::max_step(al_q[p], rd_data[p]),
					prior_s1[p]);
			end
			cur_s2 <= cur_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1   <= 1'b0;
			emit_s1    <= 1'b0;
			keep_al_s1 <= 1'b0;
			valid_s2   <= 1'b0;
		end else if (en) begin
			valid_s1   <= accept;
			emit_s1    <= row_odd_q && column_q[0];
			keep_al_s1 <= row_odd_q && !column_q[0];
			valid_s2   <= valid_s1 && emit_s1;
		end
	end

	always_comb begin
		for (int p = 0; p < mp2_pkg::LANES; p++) begin
			result[p] = mp2_pkg::max_step(m_s2[p], cur_s2[p]);
		end
	end

	assign out_valid = valid_s2;
	assign max_a     = result[0];
	assign max_b     = result[1];
	assign max_c     = result[2];
	assign max_d     = result[3];

endmodule
